// ===== design/wprm_pkg.sv =====
// shared constants and controller/datapath interface types for the level meter
package wprm_pkg;

  localparam int WIN_BITS  = 21;
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;

  localparam logic [WIN_BITS-1:0] WIN_RESET = 21'd48000;

  // register index taken from paddr[2]
  localparam logic REG_WINDOW = 1'b0;

  typedef struct packed {
    logic acc;        // fold the accepted sample into the accumulators
    logic launch;     // window closes: snapshot into the engine, clear accumulators
    logic div_step;   // one restoring division step
    logic sqrt_step;  // one digit of the square root
    logic out_load;   // move the finished measurement into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic report_due; // the next sample closes the window
  } dp_sts_t;

endpackage

// ===== design/wprm_ctrl.sv =====
// sequencer for window reports: division, square root and output handoff
module wprm_ctrl import wprm_pkg::*; #(
  parameter int SUM_BITS    = 52,
  parameter int SAMPLE_BITS = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    sample_valid_i,
  output logic    sample_stall_o,
  output logic    result_valid_o,
  input  logic    result_stall_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  localparam int CNT_BITS = $clog2(SUM_BITS);
  localparam logic [CNT_BITS-1:0] DIV_LAST  = CNT_BITS'(SUM_BITS - 1);
  localparam logic [CNT_BITS-1:0] SQRT_LAST = CNT_BITS'(SAMPLE_BITS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SQRT = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic                accept;

  // a sample that closes a window waits until the engine is free
  assign sample_stall_o = sts_i.report_due && (state_q != ST_IDLE);
  assign accept         = sample_valid_i && !sample_stall_o;
  assign result_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cmd_o         = '0;
    cmd_o.acc     = accept;
    cmd_o.launch  = accept && sts_i.report_due;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.launch) begin
          state_d = ST_DIV;
          cnt_d   = '0;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          state_d = ST_SQRT;
          cnt_d   = '0;
        end
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == SQRT_LAST) begin
          state_d = ST_HOLD;
          cnt_d   = '0;
        end
      end
      ST_HOLD: begin
        if (!out_valid_q || !result_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !result_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/wprm_dp.sv =====
// accumulators, shared divide/square-root engine and output register
module wprm_dp import wprm_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 22,
  parameter int SUM_BITS    = 52
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dp_cmd_t                       cmd_i,
  output dp_sts_t                       sts_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic [WIN_BITS-1:0]           window_length_i,
  output logic [SAMPLE_BITS-1:0]        peak_level_o,
  output logic [SAMPLE_BITS-1:0]        rms_level_o,
  output logic [COUNT_BITS-1:0]         window_samples_o
);

  localparam int CMP_BITS = (COUNT_BITS > WIN_BITS) ? COUNT_BITS : WIN_BITS;
  localparam int SREM_BITS = SAMPLE_BITS + 2;

  // accumulators
  logic [SAMPLE_BITS-1:0]   peak_q, peak_next;
  logic [SUM_BITS-1:0]      sum_q, sum_next;
  logic [COUNT_BITS-1:0]    count_q, count_inc;
  logic [SAMPLE_BITS-1:0]   mag;
  logic [2*SAMPLE_BITS-1:0] square;

  // engine
  logic [SAMPLE_BITS-1:0]   job_peak_q;
  logic [COUNT_BITS-1:0]    job_count_q;
  logic [SUM_BITS-1:0]      dq_q;
  logic [COUNT_BITS-1:0]    drem_q;
  logic [COUNT_BITS:0]      drem_sh, drem_diff;
  logic                     div_ge;
  logic [SAMPLE_BITS-1:0]   root_q;
  logic [SREM_BITS-1:0]     srem_q;
  logic [SREM_BITS+1:0]     srem_sh, srem_trial, srem_diff;
  logic                     sqrt_ge;

  // magnitude: the most negative code comes out as 2^(SAMPLE_BITS-1) unsigned
  assign mag       = sample_i[SAMPLE_BITS-1] ? (~$unsigned(sample_i) + 1'b1)
                                             : $unsigned(sample_i);
  assign square    = mag * mag;
  assign sum_next  = sum_q + SUM_BITS'(square);
  assign peak_next = (mag > peak_q) ? mag : peak_q;
  assign count_inc = count_q + 1'b1;

  // report when the count passes the window, or is about to wrap
  assign sts_o.report_due = (CMP_BITS'(count_inc) > CMP_BITS'(window_length_i))
                            || (&count_inc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q  <= '0;
      sum_q   <= '0;
      count_q <= '0;
    end else if (cmd_i.launch) begin
      peak_q  <= '0;
      sum_q   <= '0;
      count_q <= '0;
    end else if (cmd_i.acc) begin
      peak_q  <= peak_next;
      sum_q   <= sum_next;
      count_q <= count_inc;
    end
  end

  // restoring division, one quotient bit per step, quotient shifts into dq
  assign drem_sh   = {drem_q, dq_q[SUM_BITS-1]};
  assign drem_diff = drem_sh - {1'b0, job_count_q};
  assign div_ge    = drem_sh >= {1'b0, job_count_q};

  // digit-by-digit root, radicand taken two bits at a time from bit 2*SAMPLE_BITS-1 of dq downwards
  assign srem_sh    = {srem_q, dq_q[2*SAMPLE_BITS-1 -: 2]};
  assign srem_trial = {2'b00, root_q, 2'b01};
  assign srem_diff  = srem_sh - srem_trial;
  assign sqrt_ge    = srem_sh >= srem_trial;

  always_ff @(posedge clk_i) begin
    if (cmd_i.launch) begin
      job_peak_q  <= peak_next;
      job_count_q <= count_inc;
      dq_q        <= sum_next;
      drem_q      <= '0;
      root_q      <= '0;
      srem_q      <= '0;
    end else if (cmd_i.div_step) begin
      dq_q   <= {dq_q[SUM_BITS-2:0], div_ge};
      drem_q <= div_ge ? drem_diff[COUNT_BITS-1:0] : drem_sh[COUNT_BITS-1:0];
    end else if (cmd_i.sqrt_step) begin
      dq_q   <= {dq_q[SUM_BITS-3:0], 2'b00};
      root_q <= {root_q[SAMPLE_BITS-2:0], sqrt_ge};
      srem_q <= sqrt_ge ? srem_diff[SREM_BITS-1:0] : srem_sh[SREM_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      peak_level_o     <= job_peak_q;
      rms_level_o      <= root_q;
      window_samples_o <= job_count_q;
    end
  end

endmodule

// ===== design/windowed_peak_rms_meter.sv =====
// top level of the windowed peak and rms level meter
// Audio level meter. One signed sample is accepted per clock unless stalled;
// its magnitude updates a peak hold, its square a sum of squares, and a
// counter counts it. When a sample makes the count exceed window_length (APB
// register at byte address 0), or would wrap the counter, the peak, the count
// and the sum are handed to a shared divide/root engine and the accumulators
// restart at once, so sampling goes on while the report is computed. The
// engine runs a restoring division of SUM_BITS = 2*SAMPLE_BITS-2+COUNT_BITS
// quotient bits (52 by default), then a square root of SAMPLE_BITS digits
// (16), then a load into the output register. A sample that closes the next
// window is stalled while the engine is still busy, so windows shorter than
// the engine's run slow the input; otherwise one sample is taken every
// cycle. A finished result waits in the output register; the engine only
// stays busy past the root while an earlier result there has not been
// taken, and then a closing sample waits with it.
module windowed_peak_rms_meter import wprm_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 22
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          sample_valid_i,
  output logic                          sample_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          result_valid_o,
  input  logic                          result_stall_i,
  output logic [SAMPLE_BITS-1:0]        peak_level_o,
  output logic [SAMPLE_BITS-1:0]        rms_level_o,
  output logic [COUNT_BITS-1:0]         window_samples_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_BITS-1:0]          paddr,
  input  logic [DATA_BITS-1:0]          pwdata,
  output logic [DATA_BITS-1:0]          prdata,
  output logic                          pready
);

  localparam int SUM_BITS = 2*SAMPLE_BITS - 2 + COUNT_BITS;

  logic [WIN_BITS-1:0] window_q;
  dp_cmd_t             cmd;
  dp_sts_t             sts;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WIN_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW)) begin
      window_q <= pwdata[WIN_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_WINDOW) begin
      prdata = DATA_BITS'(window_q);
    end
  end

  wprm_ctrl #(
    .SUM_BITS    (SUM_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (sample_valid_i),
    .sample_stall_o (sample_stall_o),
    .result_valid_o (result_valid_o),
    .result_stall_i (result_stall_i),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  wprm_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .SUM_BITS    (SUM_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .sample_i         (sample_i),
    .window_length_i  (window_q),
    .peak_level_o     (peak_level_o),
    .rms_level_o      (rms_level_o),
    .window_samples_o (window_samples_o)
  );

  // input is only held back for a sample that would close a window
  a_stall_only_on_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_stall_o |-> sts.report_due)
    else $error("sample stalled without a pending report");

  // a report always covers at least one sample
  a_nonempty_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (window_samples_o != '0))
    else $error("report with zero samples");

  // mean square never exceeds the peak squared
  a_rms_below_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (rms_level_o <= peak_level_o))
    else $error("rms level above peak level");

endmodule
